### hdl/nls_pkg.sv
// Shared widths, register indexes and reset constants of the noise level statistics block.
package nls_pkg;

  localparam int unsigned SMP_W      = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned LSUM_W     = 48;
  localparam int unsigned CTR_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [SMP_W-1:0]  level_t;
  typedef logic [TIME_W-1:0] time_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEGAL_MS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_START   = 2'd3;

  localparam level_t            THR_RST    = 12'd4095;
  localparam time_t             PERIOD_RST = 32'd60000;
  localparam level_t            START_RST  = 12'd0;
  localparam level_t            MIN_RST    = 12'd1000;
  localparam logic [CTR_W-1:0]  CTR_RST    = 7'd50;
  localparam logic [CTR_W-1:0]  CTR_TOP    = 7'd99;
  localparam logic [CNT_W-1:0]  WARMUP_CNT = 32'd5;

endpackage

### hdl/nls_cfg_if.sv
// Configuration write channel: register index and write data.
interface nls_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [nls_pkg::CFG_IDX_W-1:0]    index;
  logic [nls_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/nls_in_if.sv
// Sample input channel: one millivolt sample with its timestamp.
interface nls_in_if;
  logic            valid;
  logic            ready;
  nls_pkg::level_t sample_mv;
  nls_pkg::time_t  now_ms;

  modport source (output valid, sample_mv, now_ms, input ready);
  modport sink   (input valid, sample_mv, now_ms, output ready);
endinterface

### hdl/nls_out_if.sv
// Result channel: the statistics after one sample.
interface nls_out_if;
  logic                          valid;
  logic                          ready;
  nls_pkg::level_t               noise_avg;
  nls_pkg::level_t               noise_avg_prev;
  nls_pkg::level_t               noise_win_avg;
  nls_pkg::level_t               noise_win_avg_max;
  nls_pkg::level_t               noise_peak;
  nls_pkg::level_t               noise_min;
  nls_pkg::level_t               low_level;
  logic [nls_pkg::CTR_W-1:0]     cycle_count;
  logic                          cycle_done;
  logic                          outlier;

  modport source (output valid, noise_avg, noise_avg_prev, noise_win_avg,
                  noise_win_avg_max, noise_peak, noise_min, low_level,
                  cycle_count, cycle_done, outlier, input ready);
  modport sink   (input valid, noise_avg, noise_avg_prev, noise_win_avg,
                  noise_win_avg_max, noise_peak, noise_min, low_level,
                  cycle_count, cycle_done, outlier, output ready);
endinterface

### hdl/noise_level_statistics.sv
// Noise level statistics: sequencer, shared serial divider and statistic registers.
//
// Usage: samples enter on in_i (sample_mv, now_ms) and every accepted sample
// yields exactly one result transaction on res_o, carrying the levels and the
// cycle counter as they stand after that sample. Registers are written on
// cfg_i, which is always ready; write only while no sample is in flight.
// Writing low_noise_start also reloads the floor and all averages.
// Sequence: an accepted sample passes the accumulate and check states, then
// the legal window division, the duty cycle division, both or neither, and
// then the done state. The shared restoring divider produces one quotient
// bit per cycle over the 12 bits of each average.
// in_i.ready is high only while the sequencer is idle, so one sample is
// processed at a time; a new sample may be taken while the previous result
// still waits in the output register.
// If the receiver stalls, the finished result of the next sample waits in the
// sequencer until the output register is free; nothing is dropped.
// Reset (rst_ni low, asynchronous) restores the configuration and statistic registers
// to their defaults, empties the output register and leaves the block idle and ready.
module noise_level_statistics #(
  parameter int unsigned SECOND_MS = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nls_cfg_if.sink     cfg_i,
  nls_in_if.sink      in_i,
  nls_out_if.source   res_o
);

  localparam nls_pkg::time_t SecondMs = nls_pkg::time_t'(SECOND_MS);
  localparam int unsigned    DivSteps = nls_pkg::SMP_W;
  localparam int unsigned    StepW    = $clog2(DivSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(DivSteps - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_LDIV = 3'd3;
  localparam logic [2:0] S_LFIN = 3'd4;
  localparam logic [2:0] S_CDIV = 3'd5;
  localparam logic [2:0] S_CFIN = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  typedef logic [nls_pkg::CNT_W-1:0]  cnt_t;
  typedef logic [nls_pkg::CTR_W-1:0]  ctr_t;
  typedef logic [nls_pkg::LSUM_W-1:0] lsum_t;

  logic [2:0] state_q, state_d;

  nls_pkg::level_t thr_q, thr_d, start_q, start_d;
  nls_pkg::time_t  legal_per_q, legal_per_d, duty_q, duty_d;

  nls_pkg::level_t smp_q, smp_d;
  nls_pkg::time_t  now_q, now_d;
  logic            outl_q, outl_d, done_q, done_d, duty_due_q, duty_due_d;

  nls_pkg::time_t  sec_mark_q, sec_mark_d, legal_mark_q, legal_mark_d;
  nls_pkg::time_t  cyc_mark_q, cyc_mark_d;
  logic [nls_pkg::TIME_W-1:0] cyc_sum_q, cyc_sum_d;
  cnt_t            cyc_cnt_q, cyc_cnt_d, leg_cnt_q, leg_cnt_d;
  lsum_t           leg_sum_q, leg_sum_d;
  nls_pkg::level_t floor_q, floor_d, peak_q, peak_d, min_q, min_d;
  nls_pkg::level_t avg_q, avg_d, avg_prev_q, avg_prev_d;
  nls_pkg::level_t leg_avg_q, leg_avg_d, leg_max_q, leg_max_d;
  ctr_t            ctr_q, ctr_d;
  logic            down_q, down_d;

  // Shared restoring divider.
  logic [31:0]            rem_q, rem_d, dvs_q, dvs_d;
  logic [DivSteps-1:0]    dvd_q, dvd_d, quo_q, quo_d;
  logic [StepW-1:0]       step_q, step_d;

  logic                   res_valid_q, res_valid_d;
  nls_pkg::level_t        r_avg_q, r_prev_q, r_legal_q, r_lmax_q, r_peak_q;
  nls_pkg::level_t        r_min_q, r_low_q;
  ctr_t                   r_ctr_q;
  logic                   r_done_q, r_outl_q, res_load;

  logic [32:0]            trial, diff;
  logic                   ge;
  logic [32:0]            cyc_add;
  logic [48:0]            leg_add;
  logic                   div_start;
  lsum_t                  div_dividend;
  logic [31:0]            div_divisor;
  logic                   down_n;

  assign trial = {rem_q, dvd_q[DivSteps-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  assign cyc_add = {1'b0, cyc_sum_q} + {21'd0, smp_q};
  assign leg_add = {1'b0, leg_sum_q} + {37'd0, smp_q};

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d      = state_q;
    thr_d        = thr_q;
    start_d      = start_q;
    legal_per_d  = legal_per_q;
    duty_d       = duty_q;
    smp_d        = smp_q;
    now_d        = now_q;
    outl_d       = outl_q;
    done_d       = done_q;
    duty_due_d   = duty_due_q;
    sec_mark_d   = sec_mark_q;
    legal_mark_d = legal_mark_q;
    cyc_mark_d   = cyc_mark_q;
    cyc_sum_d    = cyc_sum_q;
    cyc_cnt_d    = cyc_cnt_q;
    leg_sum_d    = leg_sum_q;
    leg_cnt_d    = leg_cnt_q;
    floor_d      = floor_q;
    peak_d       = peak_q;
    min_d        = min_q;
    avg_d        = avg_q;
    avg_prev_d   = avg_prev_q;
    leg_avg_d    = leg_avg_q;
    leg_max_d    = leg_max_q;
    ctr_d        = ctr_q;
    down_d       = down_q;
    rem_d        = rem_q;
    dvs_d        = dvs_q;
    dvd_d        = dvd_q;
    quo_d        = quo_q;
    step_d       = step_q;
    res_valid_d  = res_valid_q;
    res_load     = 1'b0;
    div_start    = 1'b0;
    div_dividend = leg_sum_q;
    div_divisor  = leg_cnt_q;
    down_n       = down_q;

    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        nls_pkg::CFG_OUTLIER_THR: thr_d       = cfg_i.data[nls_pkg::SMP_W-1:0];
        nls_pkg::CFG_LEGAL_MS:    legal_per_d = cfg_i.data;
        nls_pkg::CFG_DUTY_MS:     duty_d      = cfg_i.data;
        nls_pkg::CFG_LOW_START: begin
          start_d    = cfg_i.data[nls_pkg::SMP_W-1:0];
          floor_d    = cfg_i.data[nls_pkg::SMP_W-1:0];
          avg_d      = cfg_i.data[nls_pkg::SMP_W-1:0];
          avg_prev_d = cfg_i.data[nls_pkg::SMP_W-1:0];
          leg_avg_d  = cfg_i.data[nls_pkg::SMP_W-1:0];
          leg_max_d  = cfg_i.data[nls_pkg::SMP_W-1:0];
        end
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          smp_d   = in_i.sample_mv;
          now_d   = in_i.now_ms;
          outl_d  = (in_i.sample_mv > thr_q);
          done_d  = 1'b0;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (!outl_q) begin
          if (smp_q < floor_q) floor_d = smp_q;
          if (smp_q > peak_q)  peak_d  = smp_q;
          if ((now_q - sec_mark_q) > SecondMs) begin
            if (!(&cyc_cnt_q) && !cyc_add[32]) begin
              cyc_sum_d = cyc_add[31:0];
              cyc_cnt_d = cyc_cnt_q + cnt_t'(1);
            end
            sec_mark_d = now_q;
          end
          if (!(&leg_cnt_q) && !leg_add[48]) begin
            leg_sum_d = leg_add[47:0];
            leg_cnt_d = leg_cnt_q + cnt_t'(1);
          end
        end
        state_d = S_CHK;
      end
      S_CHK: begin
        duty_due_d = ((now_q - cyc_mark_q) > duty_q);
        if (!outl_q && (smp_q < min_q) && (cyc_cnt_q > nls_pkg::WARMUP_CNT)) begin
          min_d = smp_q;
        end
        if (!outl_q && ((now_q - legal_mark_q) > legal_per_q)) begin
          if (leg_cnt_q != '0) begin
            div_start = 1'b1;
            state_d   = S_LDIV;
          end else begin
            state_d = S_LFIN;
          end
        end else if ((now_q - cyc_mark_q) > duty_q) begin
          if (cyc_cnt_q != '0) begin
            div_start    = 1'b1;
            div_dividend = {16'd0, cyc_sum_q};
            div_divisor  = cyc_cnt_q;
            state_d      = S_CDIV;
          end else begin
            state_d = S_CFIN;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_LDIV: begin
        rem_d  = ge ? diff[31:0] : trial[31:0];
        dvd_d  = {dvd_q[DivSteps-2:0], 1'b0};
        quo_d  = {quo_q[DivSteps-2:0], ge};
        step_d = step_q + StepW'(1);
        if (step_q == LastStep) begin
          leg_avg_d = quo_d;
          state_d   = S_LFIN;
        end
      end
      S_LFIN: begin
        if (leg_avg_q > leg_max_q) leg_max_d = leg_avg_q;
        legal_mark_d = now_q;
        leg_sum_d    = '0;
        leg_cnt_d    = '0;
        if (duty_due_q) begin
          if (cyc_cnt_q != '0) begin
            div_start    = 1'b1;
            div_dividend = {16'd0, cyc_sum_q};
            div_divisor  = cyc_cnt_q;
            state_d      = S_CDIV;
          end else begin
            state_d = S_CFIN;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_CDIV: begin
        rem_d  = ge ? diff[31:0] : trial[31:0];
        dvd_d  = {dvd_q[DivSteps-2:0], 1'b0};
        quo_d  = {quo_q[DivSteps-2:0], ge};
        step_d = step_q + StepW'(1);
        if (step_q == LastStep) begin
          avg_d   = quo_d;
          state_d = S_CFIN;
        end
      end
      S_CFIN: begin
        // The counter turns round at the top, and at the bottom the floor is
        // reloaded from the tracked minimum.
        if (ctr_q > nls_pkg::CTR_TOP) begin
          down_n = 1'b1;
        end else if (ctr_q == '0) begin
          down_n  = 1'b0;
          floor_d = min_q;
        end
        down_d     = down_n;
        ctr_d      = down_n ? (ctr_q - ctr_t'(1)) : (ctr_q + ctr_t'(1));
        cyc_mark_d = now_q;
        cyc_sum_d  = '0;
        cyc_cnt_d  = '0;
        avg_prev_d = avg_q;
        leg_avg_d  = leg_max_q;
        done_d     = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!res_valid_q || res_o.ready) begin
          res_load    = 1'b1;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // The averages are bounded by the sample range, so the quotient fits in
    // 12 bits and the upper dividend bits start below the divisor.
    if (div_start) begin
      rem_d  = div_dividend[43:12];
      dvd_d  = div_dividend[DivSteps-1:0];
      dvs_d  = div_divisor;
      quo_d  = '0;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      thr_q        <= nls_pkg::THR_RST;
      start_q      <= nls_pkg::START_RST;
      legal_per_q  <= nls_pkg::PERIOD_RST;
      duty_q       <= nls_pkg::PERIOD_RST;
      outl_q       <= 1'b0;
      done_q       <= 1'b0;
      duty_due_q   <= 1'b0;
      sec_mark_q   <= '0;
      legal_mark_q <= '0;
      cyc_mark_q   <= '0;
      cyc_sum_q    <= '0;
      cyc_cnt_q    <= '0;
      leg_sum_q    <= '0;
      leg_cnt_q    <= '0;
      floor_q      <= nls_pkg::START_RST;
      peak_q       <= '0;
      min_q        <= nls_pkg::MIN_RST;
      avg_q        <= nls_pkg::START_RST;
      avg_prev_q   <= nls_pkg::START_RST;
      leg_avg_q    <= nls_pkg::START_RST;
      leg_max_q    <= nls_pkg::START_RST;
      ctr_q        <= nls_pkg::CTR_RST;
      down_q       <= 1'b0;
      step_q       <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      thr_q        <= thr_d;
      start_q      <= start_d;
      legal_per_q  <= legal_per_d;
      duty_q       <= duty_d;
      outl_q       <= outl_d;
      done_q       <= done_d;
      duty_due_q   <= duty_due_d;
      sec_mark_q   <= sec_mark_d;
      legal_mark_q <= legal_mark_d;
      cyc_mark_q   <= cyc_mark_d;
      cyc_sum_q    <= cyc_sum_d;
      cyc_cnt_q    <= cyc_cnt_d;
      leg_sum_q    <= leg_sum_d;
      leg_cnt_q    <= leg_cnt_d;
      floor_q      <= floor_d;
      peak_q       <= peak_d;
      min_q        <= min_d;
      avg_q        <= avg_d;
      avg_prev_q   <= avg_prev_d;
      leg_avg_q    <= leg_avg_d;
      leg_max_q    <= leg_max_d;
      ctr_q        <= ctr_d;
      down_q       <= down_d;
      step_q       <= step_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    now_q <= now_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    if (res_load) begin
      r_avg_q   <= avg_q;
      r_prev_q  <= avg_prev_q;
      r_legal_q <= leg_avg_q;
      r_lmax_q  <= leg_max_q;
      r_peak_q  <= peak_q;
      r_min_q   <= min_q;
      r_low_q   <= floor_q;
      r_ctr_q   <= ctr_q;
      r_done_q  <= done_q;
      r_outl_q  <= outl_q;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.noise_avg         = r_avg_q;
  assign res_o.noise_avg_prev    = r_prev_q;
  assign res_o.noise_win_avg     = r_legal_q;
  assign res_o.noise_win_avg_max = r_lmax_q;
  assign res_o.noise_peak        = r_peak_q;
  assign res_o.noise_min         = r_min_q;
  assign res_o.low_level         = r_low_q;
  assign res_o.cycle_count       = r_ctr_q;
  assign res_o.cycle_done        = r_done_q;
  assign res_o.outlier           = r_outl_q;

`ifndef SYNTHESIS
  a_ctr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_q <= (nls_pkg::CTR_TOP + ctr_t'(1)))
    else $error("cycle counter left its range");

  a_peak_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= $past(peak_q))
    else $error("peak level decreased");

  a_accept_to_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_ACC))
    else $error("accepted sample did not start processing");

  a_div_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LDIV || state_q == S_CDIV) |-> (step_q <= LastStep))
    else $error("divider step count overran");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_valid_q || res_o.ready))
    else $error("result overwritten while waiting");
`endif

endmodule
